### src/xor_packet_deframer_macros.svh
// Assertion macros shared by the deframer modules.
`ifndef XOR_PACKET_DEFRAMER_MACROS_SVH
`define XOR_PACKET_DEFRAMER_MACROS_SVH
`ifndef SYNTHESIS
`define XPD_ASSERT_SAME(lbl, clk_i, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deframer check failed");
`define XPD_ASSERT_NEXT(lbl, clk_i, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deframer check failed");
`else
`define XPD_ASSERT_SAME(lbl, clk_i, rst_n, ante, cons)
`define XPD_ASSERT_NEXT(lbl, clk_i, rst_n, ante, cons)
`endif
`endif

### src/xpd_pkg.sv
// Types and constants of the packet deframer.
package xpd_pkg;
	localparam int MAX_PAYLOAD = 32;
	localparam int BYTE_W      = 8;
	localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
	localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
	localparam int MAXLEN_W    = 6;
	localparam int INDEX_W     = 5;
	localparam int STATUS_W    = 2;
	localparam int CFG_IDX_W   = 2;

	localparam logic [STATUS_W-1:0] STATUS_GOOD      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_CHECK_ERR = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_TOO_LONG  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH  = 2'd2;

	localparam logic [BYTE_W-1:0]   SYNC_FIRST_RST  = 8'h06;
	localparam logic [BYTE_W-1:0]   SYNC_SECOND_RST = 8'h85;
	localparam logic [MAXLEN_W-1:0] MAX_LENGTH_RST  = 6'd32;

	typedef enum logic [2:0] {
		ST_HUNT,
		ST_SECOND,
		ST_LENGTH,
		ST_BODY,
		ST_READ,
		ST_SHOW
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_len;
		logic store_byte;
		logic load_too_long;
		logic load_check_err;
		logic rd_clear;
		logic rd_en;
		logic rd_adv;
		logic load_good;
	} xpd_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_sync_first;
		logic is_sync_second;
		logic len_zero;
		logic len_too_long;
		logic body_full;
		logic check_ok;
		logic rd_last;
		logic out_free;
	} xpd_stat_t;
endpackage

### src/xpd_ram.sv
// Generic single-port-write, registered-read RAM.
module xpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

### src/xpd_ctrl.sv
// Frame state machine of the packet deframer.
`include "xor_packet_deframer_macros.svh"
module xpd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  xpd_pkg::xpd_stat_t stat,
	output xpd_pkg::xpd_cmd_t  cmd
);
	import xpd_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   rx_phase;
	logic   acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

	assign rx_phase = (state_q == ST_HUNT) || (state_q == ST_SECOND) ||
		(state_q == ST_LENGTH) || (state_q == ST_BODY);
	// take a request only when any result it causes has room
	assign in_ready = rx_phase && stat.out_free;
	assign acc      = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_HUNT: begin
				if (acc && stat.is_sync_first) begin
					state_d = ST_SECOND;
				end
			end
			ST_SECOND: begin
				if (acc) begin
					state_d = stat.is_sync_second ? ST_LENGTH : ST_HUNT;
				end
			end
			ST_LENGTH: begin
				if (acc) begin
					priority if (stat.len_zero) begin
						state_d = ST_HUNT;
					end else if (stat.len_too_long) begin
						cmd.load_too_long = 1'b1;
						state_d           = ST_HUNT;
					end else begin
						cmd.load_len = 1'b1;
						state_d      = ST_BODY;
					end
				end
			end
			ST_BODY: begin
				if (acc) begin
					priority if (!stat.body_full) begin
						cmd.store_byte = 1'b1;
					end else if (stat.check_ok) begin
						cmd.rd_clear = 1'b1;
						state_d      = ST_READ;
					end else begin
						cmd.load_check_err = 1'b1;
						state_d            = ST_HUNT;
					end
				end
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_SHOW;
			end
			ST_SHOW: begin
				// hold the read byte until the output register frees
				if (stat.out_free) begin
					cmd.load_good = 1'b1;
					if (stat.rd_last) begin
						state_d = ST_HUNT;
					end else begin
						cmd.rd_adv = 1'b1;
						state_d    = ST_READ;
					end
				end
			end
			default: begin
				state_d = ST_HUNT;
			end
		endcase
	end

	`XPD_ASSERT_NEXT(a_good_frame_reads, clk, arst_n,
		acc && state_q == ST_BODY && stat.body_full && stat.check_ok, state_q == ST_READ)
	`XPD_ASSERT_NEXT(a_read_then_show, clk, arst_n, state_q == ST_READ, state_q == ST_SHOW)
	`XPD_ASSERT_SAME(a_no_rx_in_playback, clk, arst_n,
		state_q == ST_READ || state_q == ST_SHOW, !in_ready)
endmodule

### src/xpd_datapath.sv
// Datapath of the packet deframer: registers, payload store and output register.
`include "xor_packet_deframer_macros.svh"
module xpd_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [xpd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [xpd_pkg::BYTE_W-1:0]       cfg_data,
	input  logic [xpd_pkg::BYTE_W-1:0]       rx_byte,
	input  xpd_pkg::xpd_cmd_t                cmd,
	output xpd_pkg::xpd_stat_t               stat,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [xpd_pkg::STATUS_W-1:0]     status,
	output logic [xpd_pkg::BYTE_W-1:0]       payload_byte,
	output logic [xpd_pkg::INDEX_W-1:0]      byte_index,
	output logic                             last
);
	import xpd_pkg::*;

	logic [BYTE_W-1:0]   sync_first_q;
	logic [BYTE_W-1:0]   sync_second_q;
	logic [MAXLEN_W-1:0] max_length_q;
	logic [CNT_W-1:0]    frame_len_q;
	logic [CNT_W-1:0]    rcv_cnt_q;
	logic [BYTE_W-1:0]   check_q;
	logic [ADDR_W-1:0]   rd_idx_q;
	logic [BYTE_W-1:0]   ram_rdata;
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [BYTE_W-1:0]   payload_q;
	logic [INDEX_W-1:0]  index_q;
	logic                last_q;
	logic                load_err;
	logic                load_any;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
			max_length_q  <= MAX_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SYNC_FIRST:  sync_first_q  <= cfg_data;
				CFG_SYNC_SECOND: sync_second_q <= cfg_data;
				CFG_MAX_LENGTH:  max_length_q  <= cfg_data[MAXLEN_W-1:0];
				default: begin
					// drop writes to unknown registers
				end
			endcase
		end
	end

	// frame counters
	always_ff @(posedge clk) begin
		if (cmd.load_len) begin
			frame_len_q <= rx_byte[CNT_W-1:0];
			rcv_cnt_q   <= '0;
			check_q     <= rx_byte;
		end else if (cmd.store_byte) begin
			rcv_cnt_q <= rcv_cnt_q + CNT_W'(1);
			check_q   <= check_q ^ rx_byte;
		end
		if (cmd.rd_clear) begin
			rd_idx_q <= '0;
		end else if (cmd.rd_adv) begin
			rd_idx_q <= rd_idx_q + ADDR_W'(1);
		end
	end

	xpd_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(MAX_PAYLOAD)
	) u_store (
		.clk  (clk),
		.we   (cmd.store_byte),
		.waddr(rcv_cnt_q[ADDR_W-1:0]),
		.wdata(rx_byte),
		.re   (cmd.rd_en),
		.raddr(rd_idx_q),
		.rdata(ram_rdata)
	);

	assign stat.is_sync_first  = rx_byte == sync_first_q;
	assign stat.is_sync_second = rx_byte == sync_second_q;
	assign stat.len_zero       = rx_byte == '0;
	assign stat.len_too_long   = (rx_byte > BYTE_W'(max_length_q)) ||
		(rx_byte > BYTE_W'(MAX_PAYLOAD));
	assign stat.body_full      = rcv_cnt_q == frame_len_q;
	assign stat.check_ok       = check_q == rx_byte;
	assign stat.rd_last        = (CNT_W'(rd_idx_q) + CNT_W'(1)) == frame_len_q;
	assign stat.out_free       = !out_valid_q || out_ready;

	assign load_err = cmd.load_too_long || cmd.load_check_err;
	assign load_any = load_err || cmd.load_good;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_any) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_err) begin
			status_q  <= cmd.load_too_long ? STATUS_TOO_LONG : STATUS_CHECK_ERR;
			payload_q <= '0;
			index_q   <= '0;
			last_q    <= 1'b1;
		end else if (cmd.load_good) begin
			status_q  <= STATUS_GOOD;
			payload_q <= ram_rdata;
			index_q   <= INDEX_W'(rd_idx_q);
			last_q    <= stat.rd_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign payload_byte = payload_q;
	assign byte_index   = index_q;
	assign last         = last_q;

	`XPD_ASSERT_SAME(a_no_overwrite, clk, arst_n, load_any && out_valid_q, out_ready)
	`XPD_ASSERT_NEXT(a_error_shown, clk, arst_n, load_err, out_valid_q && last_q)
endmodule

### src/xor_packet_deframer.sv
// Top level of the length-prefixed packet deframer with XOR checksum.
//
//  channel  handshake                 payload
//  in       in_valid / in_ready       rx_byte
//  out      out_valid / out_ready     status, payload_byte, byte_index, last
//  cfg      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// in_ready is low while the output register is full and not being taken.
// A good frame plays back from the payload store, one store read and one output
// load per byte; no byte is taken meanwhile.
// Reset sets the sync bytes and maximum length to defaults and returns to hunting.
// Configuration writes are taken every cycle.
module xor_packet_deframer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [xpd_pkg::BYTE_W-1:0]   rx_byte,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [xpd_pkg::STATUS_W-1:0] status,
	output logic [xpd_pkg::BYTE_W-1:0]   payload_byte,
	output logic [xpd_pkg::INDEX_W-1:0]  byte_index,
	output logic                         last,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [xpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [xpd_pkg::BYTE_W-1:0]   cfg_data
);
	import xpd_pkg::*;

	xpd_cmd_t  cmd;
	xpd_stat_t stat;

	assign cfg_ready = 1'b1;

	xpd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	xpd_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.rx_byte     (rx_byte),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.payload_byte(payload_byte),
		.byte_index  (byte_index),
		.last        (last)
	);
endmodule
